>>> rtl/scpu_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the servo command line parser.
// No dependencies; every other file of the block refers to this package by scoped name.
package scpu_pkg;

   // Field widths
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned VALUE_WIDTH     = 10;
   localparam int unsigned COUNT_WIDTH     = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 10;

   // Default line length limit, newline included
   localparam int unsigned LINE_BUFFER_LEN_DEFAULT = 32;

   // Character codes
   localparam logic [BYTE_WIDTH-1:0] CHAR_SERVO   = 8'h53;  // 'S'
   localparam logic [BYTE_WIDTH-1:0] CHAR_ANGLE   = 8'h41;  // 'A'
   localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;  // '\n'
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;  // '9'

   // Saturation ceiling of both field accumulators
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = 10'd1023;

   // Register reset values
   localparam logic [COUNT_WIDTH-1:0] SERVO_COUNT_RESET = 8'd8;
   localparam logic [VALUE_WIDTH-1:0] ANGLE_LIMIT_RESET = 10'd180;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVO_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_LIMIT = 1'b1;

   // Result status codes
   localparam logic STATUS_PASS = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] servo_count;
      logic [VALUE_WIDTH-1:0] angle_limit;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] servo_num;
      logic [VALUE_WIDTH-1:0] angle;
      logic                   status;
   } result_type;

   // value*10 + digit, saturated at VALUE_MAX
   function automatic logic [VALUE_WIDTH-1:0] add_digit(
      input logic [VALUE_WIDTH-1:0] value,
      input logic [3:0]             digit
   );
      logic [VALUE_WIDTH+3:0] sum;
      sum = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {10'd0, digit};
      if (sum > {4'd0, VALUE_MAX}) begin
         return VALUE_MAX;
      end else begin
         return sum[VALUE_WIDTH-1:0];
      end
   endfunction

endpackage

>>> rtl/scpu_csr.sv
`timescale 1ns / 1ps
// Configuration registers of the servo command line parser: servo count and angle limit.
// Depends on scpu_pkg for widths, register indexes and reset values.
module scpu_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scpu_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [scpu_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output scpu_pkg::cfg_type                     cfg
);

   scpu_pkg::cfg_type cfg_ff;
   scpu_pkg::cfg_type cfg_in;

   // Always take a write beat
   assign csr_ready = 1'b1;

   // Decode the index and update the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            scpu_pkg::CSR_SERVO_COUNT: begin
               cfg_in.servo_count = csr_data[scpu_pkg::COUNT_WIDTH-1:0];
            end
            scpu_pkg::CSR_ANGLE_LIMIT: begin
               cfg_in.angle_limit = csr_data[scpu_pkg::VALUE_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.servo_count <= scpu_pkg::SERVO_COUNT_RESET;
         cfg_ff.angle_limit <= scpu_pkg::ANGLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/scpu_line.sv
`timescale 1ns / 1ps
// Per-line parse state: open field, id and angle accumulators, seen flags and line length.
// Depends on scpu_pkg for character codes, the digit helper and the config/result structs.
module scpu_line #(
   parameter int unsigned LINE_BUFFER_LEN = scpu_pkg::LINE_BUFFER_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [scpu_pkg::BYTE_WIDTH-1:0]   rx_byte,
   input  scpu_pkg::cfg_type                 cfg,
   output logic                              is_newline,
   output scpu_pkg::result_type              result
);

   localparam int unsigned LenWidth = $clog2(LINE_BUFFER_LEN + 1);
   localparam logic [LenWidth-1:0] LenLimit = LenWidth'(LINE_BUFFER_LEN);

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_ID,
      MODE_ANGLE
   } parse_mode_type;

   parse_mode_type                     mode_ff, mode_in;
   logic [scpu_pkg::VALUE_WIDTH-1:0]   id_value_ff, id_value_in;
   logic [scpu_pkg::VALUE_WIDTH-1:0]   angle_value_ff, angle_value_in;
   logic                               id_seen_ff, id_seen_in;
   logic                               angle_seen_ff, angle_seen_in;
   logic                               bad_byte_ff, bad_byte_in;
   logic [LenWidth-1:0]                length_ff, length_in;

   logic                               is_digit;
   logic [3:0]                         digit;
   logic                               fail;

   // Classify the byte
   assign is_newline = (rx_byte == scpu_pkg::CHAR_NEWLINE);
   assign is_digit   = (rx_byte >= scpu_pkg::CHAR_ZERO) && (rx_byte <= scpu_pkg::CHAR_NINE);
   assign digit      = 4'(rx_byte - scpu_pkg::CHAR_ZERO);

   // Advance the line state by one byte; clear it on newline
   always_comb begin
      mode_in        = mode_ff;
      id_value_in    = id_value_ff;
      angle_value_in = angle_value_ff;
      id_seen_in     = id_seen_ff;
      angle_seen_in  = angle_seen_ff;
      bad_byte_in    = bad_byte_ff;
      length_in      = length_ff;
      if (step) begin
         if (is_newline) begin
            mode_in        = MODE_NONE;
            id_value_in    = '0;
            angle_value_in = '0;
            id_seen_in     = 1'b0;
            angle_seen_in  = 1'b0;
            bad_byte_in    = 1'b0;
            length_in      = '0;
         end else begin
            if (length_ff < LenLimit) begin
               length_in = length_ff + 1'b1;
            end
            if (rx_byte == scpu_pkg::CHAR_SERVO) begin
               mode_in     = MODE_ID;
               id_seen_in  = 1'b1;
               id_value_in = '0;
            end else if (rx_byte == scpu_pkg::CHAR_ANGLE) begin
               mode_in        = MODE_ANGLE;
               angle_seen_in  = 1'b1;
               angle_value_in = '0;
            end else if (is_digit) begin
               case (mode_ff)
                  MODE_ID: begin
                     id_value_in = scpu_pkg::add_digit(id_value_ff, digit);
                  end
                  MODE_ANGLE: begin
                     angle_value_in = scpu_pkg::add_digit(angle_value_ff, digit);
                  end
                  default: begin
                     // stray digit with no field open
                     bad_byte_in = 1'b1;
                  end
               endcase
            end else begin
               bad_byte_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NONE;
         id_value_ff    <= '0;
         angle_value_ff <= '0;
         id_seen_ff     <= 1'b0;
         angle_seen_ff  <= 1'b0;
         bad_byte_ff    <= 1'b0;
         length_ff      <= '0;
      end else begin
         mode_ff        <= mode_in;
         id_value_ff    <= id_value_in;
         angle_value_ff <= angle_value_in;
         id_seen_ff     <= id_seen_in;
         angle_seen_ff  <= angle_seen_in;
         bad_byte_ff    <= bad_byte_in;
         length_ff      <= length_in;
      end
   end

   // Judge the line as it stands before the newline
   assign fail = !id_seen_ff || !angle_seen_ff || bad_byte_ff
              || (id_value_ff >= {2'b00, cfg.servo_count})
              || (angle_value_ff > cfg.angle_limit)
              || (length_ff >= LenLimit);

   assign result.servo_num = id_value_ff;
   assign result.angle     = angle_value_ff;
   assign result.status    = fail ? scpu_pkg::STATUS_FAIL : scpu_pkg::STATUS_PASS;

endmodule

>>> rtl/servo_command_line_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the servo command line parser: input byte register, line parser, result register.
// Depends on scpu_pkg, scpu_csr and scpu_line.

// Parses received bytes of lines "S<id>A<angle>" ended by newline and gives one result
// (id, angle, pass/fail) per newline; other bytes give no result. One byte is accepted
// per clock unless a newline is stalled. A byte is held in the input register, where the
// parser updates the line state; a newline that steps loads the result register, from
// which its result is offered. The only stall is a newline held in the input register
// while the previous result has not been taken; other bytes pass regardless of the
// result side.
// Configuration writes are always taken and should be made only while the block is idle.
module servo_command_line_parser_unit #(
   parameter int unsigned LINE_BUFFER_LEN = scpu_pkg::LINE_BUFFER_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [scpu_pkg::BYTE_WIDTH-1:0]       req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [scpu_pkg::VALUE_WIDTH-1:0]      rsp_servo_num,
   output logic [scpu_pkg::VALUE_WIDTH-1:0]      rsp_angle,
   output logic                                  rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scpu_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [scpu_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   scpu_pkg::cfg_type                 cfg;
   scpu_pkg::result_type              line_result;
   logic                              is_newline;

   logic                              byte_valid_ff, byte_valid_in;
   logic [scpu_pkg::BYTE_WIDTH-1:0]   byte_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   scpu_pkg::result_type              rsp_ff;

   logic                              rsp_free;
   logic                              step;
   logic                              take_req;
   logic                              load_rsp;

   scpu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scpu_line #(
      .LINE_BUFFER_LEN (LINE_BUFFER_LEN)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (byte_ff),
      .cfg        (cfg),
      .is_newline (is_newline),
      .result     (line_result)
   );

   // Advance the held byte unless it is a newline blocked by a waiting result
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign step      = byte_valid_ff && (!is_newline || rsp_free);
   assign load_rsp  = step && is_newline;
   assign req_ready = !byte_valid_ff || step;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (take_req) begin
         byte_valid_in = 1'b1;
      end else if (step) begin
         byte_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (take_req) begin
         byte_ff <= req_rx_byte;
      end
      if (load_rsp) begin
         rsp_ff <= line_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_servo_num = rsp_ff.servo_num;
   assign rsp_angle     = rsp_ff.angle;
   assign rsp_status    = rsp_ff.status;

endmodule

>>> sim/servo_command_line_parser_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the servo command line parser: feeds command lines byte by byte,
// predicts each newline's result and compares it with the block's result beats.
// Depends on scpu_pkg and servo_command_line_parser_unit.

module servo_command_line_parser_unit_test;

   typedef logic [scpu_pkg::BYTE_WIDTH-1:0] rx_byte_type;
   typedef enum logic [1:0] {FIELD_NONE, FIELD_ID, FIELD_ANGLE} field_mode_type;

   localparam int unsigned LINE_LEN     = 32;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned HALF_PERIOD  = 10;
   localparam rx_byte_type BYTE_NUL     = 8'h00;
   localparam rx_byte_type BYTE_ALL_ONE = 8'hFF;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   rx_byte_type                          req_rx_byte = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [scpu_pkg::VALUE_WIDTH-1:0]     rsp_servo_num;
   logic [scpu_pkg::VALUE_WIDTH-1:0]     rsp_angle;
   logic                                 rsp_status;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [scpu_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [scpu_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Predicted parser state and register copies
   logic [scpu_pkg::COUNT_WIDTH-1:0] cfg_servo_count;
   logic [scpu_pkg::VALUE_WIDTH-1:0] cfg_angle_limit;
   field_mode_type                   field_mode;
   logic [scpu_pkg::VALUE_WIDTH-1:0] id_acc;
   logic [scpu_pkg::VALUE_WIDTH-1:0] angle_acc;
   logic                             id_present;
   logic                             angle_present;
   logic                             junk_seen;
   int unsigned                      line_count;

   scpu_pkg::result_type expected_commands[$];
   scpu_pkg::result_type predicted;
   scpu_pkg::result_type wanted;
   int                   mismatch_count = 0;
   int                   sent_bytes = 0;
   bit                   idling_on = 1'b1;
   int                   stall_left = 0;

   servo_command_line_parser_unit #(
      .LINE_BUFFER_LEN(LINE_LEN)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_servo_num (rsp_servo_num),
      .rsp_angle     (rsp_angle),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Line predictor ---------------------------------------------------------

   function automatic void clear_parse_state();
      field_mode    = FIELD_NONE;
      id_acc        = '0;
      angle_acc     = '0;
      id_present    = 1'b0;
      angle_present = 1'b0;
      junk_seen     = 1'b0;
      line_count    = 0;
   endfunction

   // Decimal shift-in, clamped to the accumulator ceiling
   function automatic logic [scpu_pkg::VALUE_WIDTH-1:0] shift_in_digit(
      input logic [scpu_pkg::VALUE_WIDTH-1:0] value,
      input logic [3:0]                       digit
   );
      int unsigned sum;
      sum = value * 10 + digit;
      if (sum > scpu_pkg::VALUE_MAX) begin
         return scpu_pkg::VALUE_MAX;
      end
      return sum[scpu_pkg::VALUE_WIDTH-1:0];
   endfunction

   // Advance the line state by one byte; return 1 with the command result on newline
   function automatic bit parse_rx_byte(input rx_byte_type b,
                                        output scpu_pkg::result_type res);
      logic [3:0] digit;
      res = '0;
      if (b == scpu_pkg::CHAR_NEWLINE) begin
         res.servo_num = id_acc;
         res.angle     = angle_acc;
         if (!id_present || !angle_present || junk_seen || id_acc >= cfg_servo_count ||
             angle_acc > cfg_angle_limit || line_count >= LINE_LEN) begin
            res.status = scpu_pkg::STATUS_FAIL;
         end else begin
            res.status = scpu_pkg::STATUS_PASS;
         end
         clear_parse_state();
         return 1'b1;
      end
      if (line_count < LINE_LEN) begin
         line_count++;
      end
      if (b == scpu_pkg::CHAR_SERVO) begin
         field_mode = FIELD_ID;
         id_present = 1'b1;
         id_acc     = '0;
      end else if (b == scpu_pkg::CHAR_ANGLE) begin
         field_mode    = FIELD_ANGLE;
         angle_present = 1'b1;
         angle_acc     = '0;
      end else if (b >= scpu_pkg::CHAR_ZERO && b <= scpu_pkg::CHAR_NINE) begin
         digit = 4'(b - scpu_pkg::CHAR_ZERO);
         case (field_mode)
            FIELD_ID: begin
               id_acc = shift_in_digit(id_acc, digit);
            end
            FIELD_ANGLE: begin
               angle_acc = shift_in_digit(angle_acc, digit);
            end
            default: begin
               junk_seen = 1'b1;
            end
         endcase
      end else begin
         junk_seen = 1'b1;
      end
      return 1'b0;
   endfunction

   // Monitor: check result beats, track register writes, predict on byte beats
   always @(posedge clock) begin
      if (reset) begin
         cfg_servo_count = scpu_pkg::SERVO_COUNT_RESET;
         cfg_angle_limit = scpu_pkg::ANGLE_LIMIT_RESET;
         clear_parse_state();
         expected_commands.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               $error("result beat with nothing expected: servo_num %0d angle %0d status %0d",
                      rsp_servo_num, rsp_angle, rsp_status);
               mismatch_count++;
            end else begin
               wanted = expected_commands.pop_front();
               if (rsp_servo_num !== wanted.servo_num) begin
                  $error("servo_num: expected %0d, got %0d", wanted.servo_num, rsp_servo_num);
                  mismatch_count++;
               end
               if (rsp_angle !== wanted.angle) begin
                  $error("angle: expected %0d, got %0d", wanted.angle, rsp_angle);
                  mismatch_count++;
               end
               if (rsp_status !== wanted.status) begin
                  $error("status: expected %0d, got %0d", wanted.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == scpu_pkg::CSR_SERVO_COUNT) begin
               cfg_servo_count = csr_data[scpu_pkg::COUNT_WIDTH-1:0];
            end else if (csr_index == scpu_pkg::CSR_ANGLE_LIMIT) begin
               cfg_angle_limit = csr_data[scpu_pkg::VALUE_WIDTH-1:0];
            end
         end
         if (req_valid && req_ready) begin
            if (parse_rx_byte(req_rx_byte, predicted)) begin
               expected_commands.push_back(predicted);
            end
         end
      end
   end

   // Result side: stall in random bursts while idling is on
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idling_on && !reset && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus helpers -------------------------------------------------------

   function automatic void append_text(ref rx_byte_type line[$], input string text);
      for (int i = 0; i < text.len(); i++) begin
         line.push_back(rx_byte_type'(text[i]));
      end
   endfunction

   function automatic string zero_run(input int count);
      string run;
      run = "";
      for (int i = 0; i < count; i++) begin
         run = {run, "0"};
      end
      return run;
   endfunction

   // Drive a run of bytes back to back, with random gaps on some runs
   task automatic send_line(input rx_byte_type line[$]);
      bit gaps;
      int gap;
      gaps = idling_on && ($urandom_range(0, 2) != 0);
      foreach (line[i]) begin
         @(negedge clock);
         if (gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= line[i];
         do @(posedge clock); while (!req_ready);
         sent_bytes++;
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_text(input string text);
      rx_byte_type line[$];
      append_text(line, text);
      send_line(line);
   endtask

   task automatic write_register(
      input logic [scpu_pkg::CSR_INDEX_WIDTH-1:0] index,
      input logic [scpu_pkg::CSR_DATA_WIDTH-1:0]  value
   );
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain all expected results, then let the parser settle
   task automatic wait_idle();
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Tests ------------------------------------------------------------------

   // Plain commands at reset settings: in range, at the limits, above them, saturated
   task automatic test_basic_commands();
      send_text("S3A90\n");
      send_text("S0A0\n");
      send_text("S7A180\n");
      send_text("S8A10\n");
      send_text("S1A181\n");
      send_text("S12345A5\n");
      send_text("S1A54321\n");
      wait_idle();
   endtask

   // Empty fields, missing fields, field order, repeats, stray and foreign bytes
   task automatic test_special_cases();
      rx_byte_type line[$];
      send_text("SA\n");
      send_text("S4A\n");
      send_text("S2\n");
      send_text("A5\n");
      send_text("A45S2\n");
      send_text("S5S1A9A30\n");
      send_text("7S1A2\n");
      send_text("S1 A2\n");
      send_text("S1A2\r\n");
      send_text("\n");
      append_text(line, "S1");
      line.push_back(BYTE_NUL);
      append_text(line, "A2\n");
      send_line(line);
      line.delete();
      append_text(line, "S1A2");
      line.push_back(BYTE_ALL_ONE);
      line.push_back(scpu_pkg::CHAR_NEWLINE);
      send_line(line);
      wait_idle();
   endtask

   // Lines just inside, at and past the buffer length
   task automatic test_line_length();
      send_text({"S1A", zero_run(27), "5\n"});
      send_text({"S1A", zero_run(28), "5\n"});
      send_text({"S1A", zero_run(36), "5\n"});
      wait_idle();
   endtask

   // Both registers at their extremes, servo count zero, spare data bits set
   task automatic test_register_extremes();
      write_register(scpu_pkg::CSR_SERVO_COUNT, 10'd1);
      write_register(scpu_pkg::CSR_ANGLE_LIMIT, 10'd0);
      send_text("S0A0\n");
      send_text("S1A0\n");
      send_text("S0A1\n");
      wait_idle();
      write_register(scpu_pkg::CSR_SERVO_COUNT, 10'h3FF);
      write_register(scpu_pkg::CSR_ANGLE_LIMIT, 10'd1023);
      send_text("S254A1023\n");
      send_text("S255A0\n");
      send_text("S99999A99999\n");
      wait_idle();
      write_register(scpu_pkg::CSR_SERVO_COUNT, 10'd0);
      send_text("S0A0\n");
      wait_idle();
      write_register(scpu_pkg::CSR_SERVO_COUNT, 10'(scpu_pkg::SERVO_COUNT_RESET));
      write_register(scpu_pkg::CSR_ANGLE_LIMIT, scpu_pkg::ANGLE_LIMIT_RESET);
   endtask

   // Mostly well-formed commands with random content, some broken
   task automatic send_random_command();
      rx_byte_type line[$];
      int          id_val;
      int          ang_val;
      int          pick;
      int          target;
      string       body;
      id_val  = $urandom_range(0, cfg_servo_count + 2);
      ang_val = $urandom_range(0, cfg_angle_limit + 3);
      pick    = $urandom_range(0, 19);
      case (pick)
         0: begin
            body = $sformatf("S%0dA%0d", $urandom_range(0, 99999), $urandom_range(0, 99999));
         end
         1: begin
            body = $sformatf("A%0dS%0d", ang_val, id_val);
         end
         2: begin
            body = $sformatf("S%0dS%0dA%0d", $urandom_range(0, 999), id_val, ang_val);
         end
         3: begin
            body = $sformatf("S%0dA%0dA%0d", id_val, $urandom_range(0, 999), ang_val);
         end
         4: begin
            body = $sformatf("S%0d", id_val);
         end
         5: begin
            body = $sformatf("A%0d", ang_val);
         end
         6: begin
            body = ($urandom_range(0, 1) == 0) ? $sformatf("SA%0d", ang_val)
                                               : $sformatf("S%0dA", id_val);
         end
         7, 8: begin
            // pad the id with zeros to land around the buffer length
            body   = $sformatf("%0dA%0d", id_val, ang_val);
            target = $urandom_range(29, 35);
            body   = {"S", zero_run(target - 1 - body.len()), body};
         end
         default: begin
            body = $sformatf("S%0dA%0d", id_val, ang_val);
         end
      endcase
      append_text(line, body);
      if ($urandom_range(0, 7) == 0) begin
         line.insert($urandom_range(0, line.size()), rx_byte_type'($urandom_range(0, 255)));
      end
      line.push_back(scpu_pkg::CHAR_NEWLINE);
      send_line(line);
   endtask

   // Random bytes, ended by a newline only half the time
   task automatic send_noise();
      rx_byte_type line[$];
      int          count;
      count = $urandom_range(1, 12);
      repeat (count) line.push_back(rx_byte_type'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
         line.push_back(scpu_pkg::CHAR_NEWLINE);
      end
      send_line(line);
   endtask

   // Random traffic in phases, new settings per phase after the first, no idling in the last one
   task automatic test_random_traffic();
      int start;
      int count_value;
      int pick;
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4) begin
            idling_on = 1'b0;
         end
         if (phase != 0) begin
            count_value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 16);
            write_register(scpu_pkg::CSR_SERVO_COUNT,
                           10'(($urandom_range(0, 3) << 8) | count_value));
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
               write_register(scpu_pkg::CSR_ANGLE_LIMIT, 10'd0);
            end else if (pick == 1) begin
               write_register(scpu_pkg::CSR_ANGLE_LIMIT, 10'd1023);
            end else begin
               write_register(scpu_pkg::CSR_ANGLE_LIMIT, 10'($urandom_range(0, 1023)));
            end
         end
         start = sent_bytes;
         while (sent_bytes - start < 70) begin
            if ($urandom_range(0, 4) == 0) begin
               send_noise();
            end else begin
               send_random_command();
            end
         end
         wait_idle();
      end
   endtask

   // Sequence ---------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_special_cases();
      test_line_length();
      test_register_extremes();
      test_random_traffic();
      if (mismatch_count == 0) begin
         $display("servo_command_line_parser_unit_test OK");
      end else begin
         $display("servo_command_line_parser_unit_test NOT OK");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #(10_000_000);
      $display("servo_command_line_parser_unit_test NOT OK");
      $finish;
   end

endmodule
